// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the kth_smallest_select block.
// Each macro wraps one concurrent assertion clocked on clk, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kss_pkg.sv =====
// Package for the kth_smallest_select block: fixed field widths and data types.
// Used by kss_mem and kth_smallest_select; depends on nothing.
`default_nettype none

package kss_pkg;
	localparam int DATA_W = 32;
	localparam int RANK_W = 7;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [RANK_W-1:0] rank_t;
endpackage

`default_nettype wire

// ===== hdl/kss_mem.sv =====
// Element store of the kth_smallest_select block: one write port, one read port,
// read data registered. Depends on kss_pkg.
`default_nettype none

module kss_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire kss_pkg::data_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output kss_pkg::data_t     rd_data
);

	kss_pkg::data_t mem_q [DEPTH];
	kss_pkg::data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/kth_smallest_select.sv =====
// Top level of the kth_smallest_select block: load control and quickselect sequencer.
// Depends on kss_pkg, kss_mem and assert_macros.svh.
//
// Usage. Elements arrive on the item channel (item_valid/item_ready) and are
// written to the element store at one transfer per cycle while the block is idle.
// The transfer with is_last high also carries query_rank, the 1-based rank k.
// Elements offered once MAX_ITEMS are held are dropped and flag overflow.
// After the last element the block runs Lomuto partitioning in place over the
// store, pivot at the end of the current range, narrowing the bounds each pass.
// Each scanned element is read and tested; one that is swapped is written back
// with its partner in turn, as the store has a single read and a single write
// port. A bad rank (zero, or above the count) skips the selection and answers
// with value zero once the output register is free.
// The result stands on the result channel (result_valid/result_ready) in an
// output register; while the receiver stalls, the next set may start loading and
// a finished selection waits for the register to free up. item_ready is low
// during selection. Reset empties the set and the output register; the store
// content is not cleared.
`default_nettype none
`include "assert_macros.svh"

module kth_smallest_select #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic signed [31:0]   element_value,
	input  wire logic                 is_last,
	input  wire logic [6:0]           query_rank,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic signed [31:0]        kth_value,
	output logic                      rank_error,
	output logic                      overflow
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int KW = (kss_pkg::RANK_W > CW) ? kss_pkg::RANK_W : CW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PIVOT,
		S_SCAN,
		S_TEST,
		S_SWAP_A,
		S_SWAP_B,
		S_FIN_A,
		S_FIN_B,
		S_DECIDE,
		S_LAST,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              ovf_seen_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     dst_q;
	logic [CW-1:0]     rr_q;
	kss_pkg::data_t    pivot_q;
	kss_pkg::data_t    vj_q;
	kss_pkg::data_t    res_q;
	logic              err_q;
	logic              ovf_res_q;
	logic              out_valid_q;
	kss_pkg::data_t    out_value_q;
	logic              out_err_q;
	logic              out_ovf_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	kss_pkg::data_t    wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	kss_pkg::data_t    rd_data;

	logic              item_fire;
	logic              has_room;
	logic [CW-1:0]     new_count;
	logic              bad_rank;
	logic              le_pivot;
	logic [CW-1:0]     pos_rank;
	logic              out_free;

	kss_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign item_ready = (state_q == S_IDLE);
	assign item_fire  = item_valid && item_ready;
	assign has_room   = (count_q < MAX_CNT);
	assign new_count  = has_room ? (count_q + CW'(1)) : count_q;
	assign bad_rank   = (query_rank == '0) || (KW'(query_rank) > KW'(new_count));
	assign le_pivot   = ($signed(rd_data) <= $signed(pivot_q));
	assign pos_rank   = CW'(dst_q) - CW'(lo_q) + CW'(1);
	assign out_free   = !out_valid_q || result_ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				wr_en   = item_fire && has_room;
				wr_addr = count_q[AW-1:0];
				wr_data = kss_pkg::data_t'(element_value);
			end
			S_CHECK: begin
				rd_en   = 1'b1;
				rd_addr = (lo_q < hi_q) ? hi_q : lo_q;
			end
			S_SCAN: begin
				if (j_q != hi_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q;
				end else if (dst_q != hi_q) begin
					rd_en   = 1'b1;
					rd_addr = dst_q;
				end
			end
			S_TEST: begin
				if (le_pivot && (dst_q != j_q)) begin
					rd_en   = 1'b1;
					rd_addr = dst_q;
				end
			end
			S_SWAP_A: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = rd_data;
			end
			S_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = dst_q;
				wr_data = vj_q;
			end
			S_FIN_A: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = rd_data;
			end
			S_FIN_B: begin
				wr_en   = 1'b1;
				wr_addr = dst_q;
				wr_data = pivot_q;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_seen_q  <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			j_q         <= '0;
			dst_q       <= '0;
			rr_q        <= '0;
			pivot_q     <= '0;
			vj_q        <= '0;
			res_q       <= '0;
			err_q       <= 1'b0;
			ovf_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_err_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						if (!has_room) begin
							ovf_seen_q <= 1'b1;
						end
						count_q <= new_count;
						if (is_last) begin
							count_q    <= '0;
							ovf_seen_q <= 1'b0;
							ovf_res_q  <= ovf_seen_q || !has_room;
							err_q      <= bad_rank;
							res_q      <= '0;
							lo_q       <= '0;
							hi_q       <= AW'(new_count - CW'(1));
							rr_q       <= CW'(query_rank);
							state_q    <= bad_rank ? S_FINISH : S_CHECK;
						end
					end
				end
				S_CHECK: begin
					state_q <= (lo_q < hi_q) ? S_PIVOT : S_LAST;
				end
				S_PIVOT: begin
					pivot_q <= rd_data;
					j_q     <= lo_q;
					dst_q   <= lo_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (j_q != hi_q) begin
						state_q <= S_TEST;
					end else if (dst_q != hi_q) begin
						state_q <= S_FIN_A;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_TEST: begin
					vj_q <= rd_data;
					if (le_pivot && (dst_q != j_q)) begin
						state_q <= S_SWAP_A;
					end else begin
						if (le_pivot) begin
							dst_q <= dst_q + AW'(1);
						end
						j_q     <= j_q + AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SWAP_A: begin
					state_q <= S_SWAP_B;
				end
				S_SWAP_B: begin
					dst_q   <= dst_q + AW'(1);
					j_q     <= j_q + AW'(1);
					state_q <= S_SCAN;
				end
				S_FIN_A: begin
					state_q <= S_FIN_B;
				end
				S_FIN_B: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (rr_q == pos_rank) begin
						res_q   <= pivot_q;
						state_q <= S_FINISH;
					end else if (rr_q < pos_rank) begin
						hi_q    <= dst_q - AW'(1);
						state_q <= S_CHECK;
					end else begin
						lo_q    <= dst_q + AW'(1);
						rr_q    <= rr_q - pos_rank;
						state_q <= S_CHECK;
					end
				end
				S_LAST: begin
					res_q   <= rd_data;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_err_q   <= err_q;
						out_ovf_q   <= ovf_res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign kth_value    = $signed(out_value_q);
	assign rank_error   = out_err_q;
	assign overflow     = out_ovf_q;

	`KSS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= MAX_CNT, "element count exceeds store depth")
	`KSS_ASSERT_SAME(a_bounds_order,
		(state_q == S_CHECK) || (state_q == S_PIVOT) || (state_q == S_SCAN),
		(lo_q <= hi_q) && (j_q <= hi_q || state_q != S_SCAN),
		"selection bounds out of order")
	`KSS_ASSERT_SAME(a_rank_in_range, (state_q == S_CHECK),
		(rr_q != '0) && (CW'(rr_q - CW'(1)) <= CW'(CW'(hi_q) - CW'(lo_q))),
		"remaining rank outside the current range")
	`KSS_ASSERT_SAME(a_result_source, $rose(result_valid), $past(state_q == S_FINISH),
		"result presented without a finished selection")

endmodule

`default_nettype wire
